/* rtl/core/kronecker_product_block_scaler_top_macros.svh */
// assertion macros for the kronecker product block scaler
// each check is sampled on the rising edge of clk and is off during reset
`ifndef KRONECKER_PRODUCT_BLOCK_SCALER_TOP_MACROS_SVH
`define KRONECKER_PRODUCT_BLOCK_SCALER_TOP_MACROS_SVH

// same-cycle implication
`define KPS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/kps_pkg.sv */
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types, constants and helpers of the kronecker product block scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package kps_pkg;

  // size of the B store
  localparam int B_ROWS_MAX  = 8;
  localparam int B_COLS_MAX  = 8;
  localparam int ROW_IDX_W   = $clog2(B_ROWS_MAX);
  localparam int COL_IDX_W   = $clog2(B_COLS_MAX);
  localparam int ADDR_W      = ROW_IDX_W + COL_IDX_W;
  localparam int STORE_DEPTH = 2 ** ADDR_W;

  // configuration port
  localparam int SIZE_W      = 4;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_B = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS_IN_B = 2'd1;

  // request function codes
  localparam logic FUNC_LOAD_B = 1'b0;
  localparam logic FUNC_A_ELEM = 1'b1;

  typedef struct packed {
    logic               func;
    logic [5:0]         elem_row;
    logic [5:0]         elem_col;
    logic signed [15:0] elem_value;
  } kps_in_t;

  typedef struct packed {
    logic [8:0]         out_row;
    logic [8:0]         out_col;
    logic signed [31:0] product;
    logic               last;
  } kps_out_t;

  // controller to datapath
  typedef struct packed {
    logic load_a;
    logic write_b;
    logic issue;
  } kps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic advance;
    logic last_pos;
    logic s1_valid;
  } kps_stat_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/kronecker_product_block_scaler_top.sv */
// ----------------------------------------------------------------------------
// kronecker_product_block_scaler_top
// Kronecker product A (x) B engine in signed Q8.8, products in Q16.16.
//
// Channels: in (valid/ready, kps_in_t), out (valid/ready, kps_out_t) and a
// configuration write channel (cfg_valid/cfg_ready, cfg_index, cfg_data)
// that is always ready; index 0 sets rows_in_b, index 1 sets cols_in_b.
// A request with func = load B writes one B entry and gives no
// result; entries outside the configured size are dropped.
// A request with func = A element sweeps the B store in row-major order and
// gives rows*cols results, last set on the final one. Each result passes the
// store read stage and then the output register, one result per cycle while
// out_ready is high; the single store read port and multiplier set the rate.
// No request is taken until an A element's sweep has left the read stage.
// When out_ready is low the sweep freezes in place and resumes without loss.
// Reset (rst, synchronous) sets both sizes to 1 and empties the pipeline; the
// B store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kronecker_product_block_scaler_top_macros.svh"

module kronecker_product_block_scaler_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [kps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [kps_pkg::SIZE_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire kps_pkg::kps_in_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output kps_pkg::kps_out_t                    out_data
);
  import kps_pkg::*;

  kps_cmd_t  cmd;
  kps_stat_t stat;

  // size registers take writes at any time
  assign cfg_ready = 1'b1;

  // sequencer
  kps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (in_data.func),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store, multiplier and output register
  kps_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  `KPS_ASSERT_NEXT(a_busy_after_start, cmd.load_a, !in_ready, "block idle right after start")
  `KPS_ASSERT_NEXT(a_read_holds, stat.s1_valid && !stat.advance, stat.s1_valid, "read stage lost")
  `KPS_ASSERT_SAME(a_no_write_in_flight, cmd.write_b, !stat.s1_valid, "store written mid read")

endmodule

`default_nettype wire

/* rtl/core/kps_ctrl.sv */
// ----------------------------------------------------------------------------
// kps_ctrl
// Sequencer: takes requests, starts a B-store sweep for each A element and
// steps it one position per advancing cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             func,
  input  wire kps_pkg::kps_stat_t stat,
  output kps_pkg::kps_cmd_t     cmd
);
  import kps_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  // take a request only when idle and no store read is in flight
  assign in_ready = (state == ST_IDLE) && !stat.s1_valid;
  assign accept   = in_valid && in_ready;

  // commands
  always_comb begin
    cmd.load_a  = accept && (func == FUNC_A_ELEM);
    cmd.write_b = accept && (func == FUNC_LOAD_B);
    cmd.issue   = (state == ST_RUN) && stat.advance;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (func == FUNC_A_ELEM)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.advance && stat.last_pos) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/kps_datapath.sv */
// ----------------------------------------------------------------------------
// kps_datapath
// Size registers, B store, sweep counters, store read stage, multiplier and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kps_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [kps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [kps_pkg::SIZE_W-1:0]   cfg_data,
  input  wire kps_pkg::kps_in_t             in_data,
  input  wire kps_pkg::kps_cmd_t            cmd,
  output kps_pkg::kps_stat_t                stat,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output kps_pkg::kps_out_t                 out_data
);
  import kps_pkg::*;

  logic [SIZE_W-1:0]    rows_in_b;
  logic [SIZE_W-1:0]    cols_in_b;
  logic [SIZE_W-1:0]    nr_eff;
  logic [SIZE_W-1:0]    nc_eff;
  logic [ROW_IDX_W-1:0] k_last;
  logic [COL_IDX_W-1:0] l_last;

  logic signed [15:0]   mem [STORE_DEPTH];
  logic                 b_in_range;

  logic signed [15:0]   a_val;
  logic [8:0]           base_row;
  logic [8:0]           base_col;
  logic [9:0]           row_base_full;
  logic [9:0]           col_base_full;
  logic [ROW_IDX_W-1:0] k;
  logic [COL_IDX_W-1:0] l;

  logic                 s1_valid;
  logic signed [15:0]   b_data;
  logic [8:0]           s1_row;
  logic [8:0]           s1_col;
  logic                 s1_last;

  logic                 advance;
  logic                 last_pos;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_b <= SIZE_W'(1);
      cols_in_b <= SIZE_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_ROWS_IN_B) begin
        rows_in_b <= cfg_data;
      end else if (cfg_index == REG_COLS_IN_B) begin
        cols_in_b <= cfg_data;
      end
    end
  end

  assign nr_eff = clamp_size(rows_in_b, SIZE_W'(B_ROWS_MAX));
  assign nc_eff = clamp_size(cols_in_b, SIZE_W'(B_COLS_MAX));
  assign k_last = ROW_IDX_W'(nr_eff - SIZE_W'(1));
  assign l_last = COL_IDX_W'(nc_eff - SIZE_W'(1));

  // sweep status
  assign advance  = !out_valid || out_ready;
  assign last_pos = (k == k_last) && (l == l_last);

  always_comb begin
    stat.advance  = advance;
    stat.last_pos = last_pos;
    stat.s1_valid = s1_valid;
  end

  // B store, entries outside the configured size are dropped
  assign b_in_range = (in_data.elem_row < 6'(nr_eff)) && (in_data.elem_col < 6'(nc_eff));

  always_ff @(posedge clk) begin
    if (cmd.write_b && b_in_range) begin
      mem[{in_data.elem_row[ROW_IDX_W-1:0], in_data.elem_col[COL_IDX_W-1:0]}] <=
        in_data.elem_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      b_data <= mem[{k, l}];
    end
  end

  // coordinate bases of the A element
  always_comb begin
    row_base_full = {6'b0, nr_eff} * {4'b0, in_data.elem_row};
    col_base_full = {6'b0, nc_eff} * {4'b0, in_data.elem_col};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_val    <= in_data.elem_value;
      base_row <= row_base_full[8:0];
      base_col <= col_base_full[8:0];
    end
  end

  // row-major sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
      l <= '0;
    end else if (cmd.load_a) begin
      k <= '0;
      l <= '0;
    end else if (cmd.issue) begin
      if (l == l_last) begin
        l <= '0;
        k <= k + ROW_IDX_W'(1);
      end else begin
        l <= l + COL_IDX_W'(1);
      end
    end
  end

  // read stage tags
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_row  <= base_row + {{(9-ROW_IDX_W){1'b0}}, k};
      s1_col  <= base_col + {{(9-COL_IDX_W){1'b0}}, l};
      s1_last <= last_pos;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= cmd.issue;
      out_valid <= s1_valid;
    end
  end

  // multiply into the output register
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data.out_row <= s1_row;
      out_data.out_col <= s1_col;
      out_data.product <= a_val * b_data;
      out_data.last    <= s1_last;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_kronecker_product_block_scaler_top.sv */
// ----------------------------------------------------------------------------
// tb_kronecker_product_block_scaler_top
// Self-checking bench for the Kronecker product block scaler. A short table
// of directed requests is walked first. Then come phases of random traffic
// over several B sizes. Each phase loads the active B region and then mixes
// A elements with B loads, some of them out of range. Every result is checked
// field by field against a hand-typed value or an in-bench predictor of the sweep.
// ----------------------------------------------------------------------------
module tb_kronecker_product_block_scaler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kps_pkg::*;

  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_REQUESTS = 25;
  localparam int SETTLE_CYCLES  = 8;
  localparam int FINAL_CYCLES   = 70;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int IDLE_PCT       = 27;

  // register indexes past the two real ones, which the block must ignore
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    kps_in_t                 req;
    logic [CFG_INDEX_W-1:0]  cfg_idx;
    logic [SIZE_W-1:0]       cfg_val;
    logic                    known;
    kps_out_t                res;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]      cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  kps_in_t                in_data;
  logic                   out_valid;
  logic                   out_ready;
  kps_out_t               out_data;

  // side band that travels with a request whose result is typed in the table
  logic                   in_known;
  kps_out_t               in_known_res;

  // predictor state
  logic [SIZE_W-1:0]      rows_reg;
  logic [SIZE_W-1:0]      cols_reg;
  logic signed [15:0]     b_words [STORE_DEPTH];
  kps_out_t               expected_products [$];

  int mismatch_count = 0;
  int n_requests     = 0;
  int n_elems        = 0;
  int n_products     = 0;
  int n_reg_writes   = 0;
  int quiet_cycles   = 0;
  int idle_pct       = IDLE_PCT;
  int hold_asks      = 0;
  int hold_done      = 0;

  kronecker_product_block_scaler_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // zero acts as one, sizes past the store act as the store size
  function automatic int eff_dim(input logic [SIZE_W-1:0] v, input int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // a B load updates the store, an A element sweeps it
  task automatic predict_products(input kps_in_t req);
    int nr;
    int nc;
    int idx;
    kps_out_t res;
    nr = eff_dim(rows_reg, B_ROWS_MAX);
    nc = eff_dim(cols_reg, B_COLS_MAX);
    if (req.func == FUNC_LOAD_B) begin
      if (int'(req.elem_row) < nr && int'(req.elem_col) < nc) begin
        b_words[int'(req.elem_row) * B_COLS_MAX + int'(req.elem_col)] = req.elem_value;
      end
    end else begin
      for (int k = 0; k < nr; k++) begin
        for (int l = 0; l < nc; l++) begin
          idx = k * B_COLS_MAX + l;
          res.out_row = 9'(nr * int'(req.elem_row) + k);
          res.out_col = 9'(nc * int'(req.elem_col) + l);
          res.product = $signed(req.elem_value) * $signed(b_words[idx]);
          res.last    = (k == nr - 1) && (l == nc - 1);
          expected_products.push_back(res);
        end
      end
    end
  endtask

  task automatic report_result(input string what, input kps_out_t want, input kps_out_t got);
    if (mismatch_count < 10) begin
      $display("%s: want row %0d col %0d product %h last %b, got row %0d col %0d product %h last %b",
               what, want.out_row, want.out_col, want.product, want.last,
               got.out_row, got.out_col, got.product, got.last);
    end
    mismatch_count++;
  endtask

  // monitor: register writes, taken requests and delivered results
  always @(posedge clk) begin
    kps_out_t want;
    if (rst) begin
      rows_reg <= SIZE_W'(1);
      cols_reg <= SIZE_W'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        n_reg_writes++;
        if (cfg_index == REG_ROWS_IN_B) rows_reg <= cfg_data;
        else if (cfg_index == REG_COLS_IN_B) cols_reg <= cfg_data;
      end
      if (in_valid && in_ready) begin
        n_requests++;
        if (in_data.func == FUNC_A_ELEM) n_elems++;
        if (in_known) expected_products.push_back(in_known_res);
        else predict_products(in_data);
      end
      if (out_valid && out_ready) begin
        n_products++;
        if (expected_products.size() == 0) begin
          report_result("unexpected result", '0, out_data);
        end else begin
          want = expected_products.pop_front();
          if (out_data.out_row !== want.out_row || out_data.out_col !== want.out_col ||
              out_data.product !== want.product || out_data.last !== want.last) begin
            report_result("mismatch", want, out_data);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_products.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random back pressure plus one long hold when asked
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_asks) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // offer one request, with random gaps in front of it
  task automatic offer(input kps_in_t req, input logic known, input kps_out_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data      <= req;
    in_known     <= known;
    in_known_res <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending, wait for every result, then let the block settle
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly A elements, then in-range B loads, then loads anywhere
  function automatic kps_in_t random_request(input int nr, input int nc);
    kps_in_t r;
    int pick;
    pick         = $urandom_range(99);
    r.elem_value = pick_value();
    if (pick < 6) begin
      r.func     = FUNC_A_ELEM;
      r.elem_row = $urandom_range(1) ? 6'd63 : 6'd0;
      r.elem_col = $urandom_range(1) ? 6'd63 : 6'd0;
    end else if (pick < 60) begin
      r.func     = FUNC_A_ELEM;
      r.elem_row = 6'($urandom_range(63));
      r.elem_col = 6'($urandom_range(63));
    end else if (pick < 85) begin
      r.func     = FUNC_LOAD_B;
      r.elem_row = 6'($urandom_range(nr - 1));
      r.elem_col = 6'($urandom_range(nc - 1));
    end else begin
      r.func     = FUNC_LOAD_B;
      r.elem_row = 6'($urandom_range(63));
      r.elem_col = 6'($urandom_range(63));
    end
    return r;
  endfunction

  function automatic stim_row_t stim_load(input int r, input int c, input logic [15:0] v);
    stim_row_t s;
    s = '{ROW_REQ, '0, '0, '0, 1'b0, '0};
    s.req = '{FUNC_LOAD_B, 6'(r), 6'(c), v};
    return s;
  endfunction

  function automatic stim_row_t stim_elem(input int r, input int c, input logic [15:0] v);
    stim_row_t s;
    s = '{ROW_REQ, '0, '0, '0, 1'b0, '0};
    s.req = '{FUNC_A_ELEM, 6'(r), 6'(c), v};
    return s;
  endfunction

  // single-product sweep whose result is written out by hand
  function automatic stim_row_t stim_elem_known(input int r, input int c, input logic [15:0] v,
                                                input int orow, input int ocol,
                                                input logic [31:0] prod);
    stim_row_t s;
    s = stim_elem(r, c, v);
    s.known = 1'b1;
    s.res   = '{9'(orow), 9'(ocol), prod, 1'b1};
    return s;
  endfunction

  function automatic stim_row_t stim_reg(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [SIZE_W-1:0] val);
    stim_row_t s;
    s = '{ROW_CFG, '0, idx, val, 1'b0, '0};
    return s;
  endfunction

  // request side
  initial begin
    stim_row_t   directed_rows [19];
    logic [3:0]  phase_rows [8];
    logic [3:0]  phase_cols [8];
    logic [3:0]  rows_set;
    logic [3:0]  cols_set;
    int          nr;
    int          nc;

    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    in_known     = 1'b0;
    in_known_res = '0;

    // sizes after reset are 1x1, so each sweep before the register writes gives one product
    directed_rows = '{
      stim_load(0, 0, 16'h0100),
      stim_elem_known(0, 0, 16'h0100, 0, 0, 32'h0001_0000),
      stim_elem_known(63, 63, 16'h7FFF, 63, 63, 32'h007F_FF00),
      stim_load(0, 0, 16'h8000),
      stim_elem_known(5, 9, 16'h8000, 5, 9, 32'h4000_0000),
      stim_elem_known(0, 0, 16'h7FFF, 0, 0, 32'hC000_8000),
      // loads outside the 1x1 region leave the store alone
      stim_load(1, 0, 16'h1111),
      stim_load(63, 63, 16'h2222),
      stim_elem_known(1, 2, 16'hFFFF, 1, 2, 32'h0000_8000),
      stim_load(0, 0, 16'h7FFF),
      stim_elem_known(42, 21, 16'h7FFF, 42, 21, 32'h3FFF_0001),
      stim_load(0, 0, 16'h0000),
      stim_elem_known(21, 42, 16'h8000, 21, 42, 32'h0000_0000),
      // zero rows acts as one, spare indexes do nothing
      stim_reg(REG_ROWS_IN_B, 4'd0),
      stim_reg(REG_COLS_IN_B, 4'd2),
      stim_reg(REG_SPARE_2, 4'd15),
      stim_reg(REG_SPARE_3, 4'd0),
      stim_load(0, 1, 16'hC000),
      stim_elem(63, 63, 16'h0100)
    };
    phase_rows = '{4'd8, 4'd15, 4'd0, 4'd3, 4'd9, 4'd1, 4'd2, 4'd8};
    phase_cols = '{4'd8, 4'd15, 4'd0, 4'd5, 4'd1, 4'd12, 4'd7, 4'd3};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_for_quiet();
        write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
      end else begin
        offer(directed_rows[i].req, directed_rows[i].known, directed_rows[i].res);
      end
    end

    // random phases over a spread of B sizes
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_for_quiet();
      rows_set = (ph < 8) ? phase_rows[ph] : 4'($urandom_range(15));
      cols_set = (ph < 8) ? phase_cols[ph] : 4'($urandom_range(15));
      write_reg(REG_ROWS_IN_B, rows_set);
      write_reg(REG_COLS_IN_B, cols_set);
      nr = eff_dim(rows_set, B_ROWS_MAX);
      nc = eff_dim(cols_set, B_COLS_MAX);
      // one full phase runs with no idling on either side
      idle_pct = (ph == 2) ? 0 : IDLE_PCT;

      // fill the active region before any sweep reads it
      for (int k = 0; k < nr; k++) begin
        for (int l = 0; l < nc; l++) begin
          offer('{FUNC_LOAD_B, 6'(k), 6'(l), pick_value()}, 1'b0, '0);
        end
      end

      // long output hold while requests keep coming
      if (ph == 0 || ph == 6) begin
        offer('{FUNC_A_ELEM, 6'($urandom_range(63)), 6'($urandom_range(63)), pick_value()},
              1'b0, '0);
        hold_asks++;
      end

      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (n == PHASE_REQUESTS / 2 && (ph % 3) == 1) wait_for_quiet();
        offer(random_request(nr, nc), 1'b0, '0);
      end
    end

    wait_for_quiet();
    repeat (FINAL_CYCLES) @(posedge clk);
    if (expected_products.size() != 0) begin
      $display("%0d results never arrived", expected_products.size());
      mismatch_count += expected_products.size();
    end

    $display("run: %0d requests taken, %0d of them A elements, %0d products checked",
             n_requests, n_elems, n_products);
    $display("run: %0d register writes over %0d B sizes, %0d mismatches",
             n_reg_writes, PHASE_COUNT + 2, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
